// File: hdl/lbfv_pkg.sv
// ----------------------------------------------------------------------------
// lbfv_pkg
// Types, codes, stage counts and rounding helper shared by the Lorentz boost.
// ----------------------------------------------------------------------------
package lbfv_pkg;

	localparam int unsigned SQ_STEPS  = 32;
	localparam int unsigned DIV_STEPS = 55;
	localparam int unsigned MUL_LAT   = 4;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
	localparam int unsigned FRONT_LAT = 3;
	localparam int unsigned LATENCY   = FRONT_LAT + 1 + SQ_STEPS + 2 * DIV_STEPS
		+ 2 * MUL_LAT + 2;

	localparam logic [1:0] ST_BOOST = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_FAST  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic [47:0] ONE_Q44 = 48'h1000_0000_0000;

	typedef struct packed {
		logic signed [31:0] energy_in;
		logic signed [31:0] mom_x_in;
		logic signed [31:0] mom_y_in;
		logic signed [31:0] mom_z_in;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_z;
	} lbfv_in_t;

	typedef struct packed {
		logic signed [31:0] energy_out;
		logic signed [31:0] mom_x_out;
		logic signed [31:0] mom_y_out;
		logic signed [31:0] mom_z_out;
		logic [1:0]         status;
	} lbfv_out_t;

	typedef struct packed {
		lbfv_in_t           vec;
		logic signed [57:0] vdp;
		logic [1:0]         kind;
	} lbfv_item_t;

	typedef struct packed {
		lbfv_item_t  item;
		logic [47:0] vsq;
	} lbfv_qent_t;

	typedef struct packed {
		logic       vld;
		lbfv_qent_t ent;
	} lbfv_qlink_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} lbfv_rs_t;

	function automatic lbfv_rs_t rsat(input logic signed [159:0] a, input int unsigned k);
		logic signed [159:0] h;
		logic signed [159:0] r;
		lbfv_rs_t o;
		h = 160'sd1 <<< (k - 1);
		r = (a + h) >>> k;
		if (r > 160'sd2147483647) begin
			o.val = 32'h7FFF_FFFF;
			o.sat = 1'b1;
		end else if (r < -160'sd2147483648) begin
			o.val = 32'h8000_0000;
			o.sat = 1'b1;
		end else begin
			o.val = r[31:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

endpackage

// File: hdl/lbfv_mul.sv
// ----------------------------------------------------------------------------
// lbfv_mul
// Signed 96 x 64 multiplier, four stages: magnitudes, 32x32 partial
// products, partial product sum, sign restore.
// ----------------------------------------------------------------------------
module lbfv_mul (
	input  logic                clk,
	input  logic signed [95:0]  a,
	input  logic signed [63:0]  b,
	output logic signed [159:0] p
);

	logic [95:0]  ma_s1;
	logic [63:0]  mb_s1;
	logic         neg_s1;
	logic [63:0]  pp_s2 [3][2];
	logic         neg_s2;
	logic [159:0] sum_s3;
	logic         neg_s3;
	logic [159:0] acc;

	always_comb begin
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 2; j++) begin
				acc = acc + ({96'b0, pp_s2[i][j]} << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		ma_s1  <= a[95] ? 96'(-a) : 96'(a);
		mb_s1  <= b[63] ? 64'(-b) : 64'(b);
		neg_s1 <= a[95] ^ b[63];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 2; j++) begin
				pp_s2[i][j] <= ma_s1[32 * i +: 32] * mb_s1[32 * j +: 32];
			end
		end
		neg_s2 <= neg_s1;
		sum_s3 <= acc;
		neg_s3 <= neg_s2;
		p      <= neg_s3 ? -$signed(sum_s3) : $signed(sum_s3);
	end

endmodule

// File: hdl/lbfv_front.sv
// ----------------------------------------------------------------------------
// lbfv_front
// Accepts items, forms v squared and v dot p, classifies each item and
// pushes it into the work queue.
// ----------------------------------------------------------------------------
module lbfv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  lbfv_pkg::lbfv_in_t        item,
	input  logic [lbfv_pkg::QCNT_W-1:0] cnt,
	output logic                      busy,
	output lbfv_pkg::lbfv_qlink_t     push
);

	lbfv_pkg::lbfv_in_t item_s1;
	lbfv_pkg::lbfv_in_t item_s2;
	logic               vld_s1;
	logic               vld_s2;
	logic signed [47:0] sq_s2 [3];
	logic signed [55:0] pr_s2 [3];
	logic [lbfv_pkg::QCNT_W:0] occ;
	logic [47:0]        vsq;
	logic signed [57:0] vdp;
	logic               acc;

	assign occ  = (lbfv_pkg::QCNT_W + 1)'(cnt) + (lbfv_pkg::QCNT_W + 1)'(vld_s1)
		+ (lbfv_pkg::QCNT_W + 1)'(vld_s2);
	assign busy = occ >= (lbfv_pkg::QCNT_W + 1)'(lbfv_pkg::QDEPTH);
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item;
		end
		item_s2  <= item_s1;
		sq_s2[0] <= item_s1.vel_x * item_s1.vel_x;
		sq_s2[1] <= item_s1.vel_y * item_s1.vel_y;
		sq_s2[2] <= item_s1.vel_z * item_s1.vel_z;
		pr_s2[0] <= item_s1.vel_x * item_s1.mom_x_in;
		pr_s2[1] <= item_s1.vel_y * item_s1.mom_y_in;
		pr_s2[2] <= item_s1.vel_z * item_s1.mom_z_in;
	end

	always_comb begin
		vsq = $unsigned(sq_s2[0]) + $unsigned(sq_s2[1]) + $unsigned(sq_s2[2]);
		vdp = 58'(pr_s2[0]) + 58'(pr_s2[1]) + 58'(pr_s2[2]);
		push.vld          = vld_s2;
		push.ent.vsq      = vsq;
		push.ent.item.vec = item_s2;
		push.ent.item.vdp = vdp;
		if (vsq == 48'd0) begin
			push.ent.item.kind = lbfv_pkg::ST_ZERO;
		end else if (vsq >= lbfv_pkg::ONE_Q44) begin
			push.ent.item.kind = lbfv_pkg::ST_FAST;
		end else begin
			push.ent.item.kind = lbfv_pkg::ST_BOOST;
		end
	end

endmodule

// File: hdl/lbfv_queue.sv
// ----------------------------------------------------------------------------
// lbfv_queue
// Short work queue between front and back; the back drains it every cycle.
// ----------------------------------------------------------------------------
module lbfv_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbfv_pkg::lbfv_qlink_t       push,
	output lbfv_pkg::lbfv_qlink_t       head,
	output logic [lbfv_pkg::QCNT_W-1:0] cnt
);

	lbfv_pkg::lbfv_qent_t mem_q [lbfv_pkg::QDEPTH];
	logic [lbfv_pkg::QPTR_W-1:0] wptr_q;
	logic [lbfv_pkg::QPTR_W-1:0] rptr_q;
	logic [lbfv_pkg::QCNT_W-1:0] cnt_q;
	logic                        pop;

	assign pop      = cnt_q != '0;
	assign head.vld = pop;
	assign head.ent = mem_q[rptr_q];
	assign cnt      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.vld) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + lbfv_pkg::QCNT_W'(push.vld) - lbfv_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wptr_q] <= push.ent;
		end
	end

endmodule

// File: hdl/lbfv_back.sv
// ----------------------------------------------------------------------------
// lbfv_back
// Carries out the boost: square root of 1 - v^2, gamma and the combined
// coefficient by pipelined restoring division, then the wide products,
// rounding and saturation.
// ----------------------------------------------------------------------------
module lbfv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lbfv_pkg::lbfv_qlink_t head,
	output logic                  done,
	output lbfv_pkg::lbfv_out_t   result
);

	localparam int unsigned SQN = lbfv_pkg::SQ_STEPS;
	localparam int unsigned DVN = lbfv_pkg::DIV_STEPS;
	localparam int unsigned MLN = lbfv_pkg::MUL_LAT;

	typedef struct packed {
		lbfv_pkg::lbfv_item_t item;
		logic [35:0]          rem;
		logic [31:0]          root;
		logic [63:0]          x;
	} sq_t;

	typedef struct packed {
		lbfv_pkg::lbfv_item_t item;
		logic [33:0]          rem;
		logic [31:0]          s;
		logic [54:0]          q;
	} d1_t;

	typedef struct packed {
		lbfv_pkg::lbfv_item_t item;
		logic [33:0]          rem;
		logic [32:0]          t;
		logic [54:0]          nb;
		logic [54:0]          gam;
		logic [54:0]          q;
	} d2_t;

	logic                 vld_s0;
	lbfv_pkg::lbfv_item_t item_s0;
	logic [63:0]          x_s0;
	logic [47:0]          dsub;

	sq_t sq_init;
	sq_t sq_q   [SQN];
	sq_t sq_nxt [SQN];
	logic [SQN-1:0] sq_vld_q;

	d1_t d1_init;
	d1_t d1_q   [DVN];
	d1_t d1_nxt [DVN];
	logic [DVN-1:0] d1_vld_q;

	d2_t d2_init;
	d2_t d2_q   [DVN];
	d2_t d2_nxt [DVN];
	logic [DVN-1:0] d2_vld_q;

	d2_t dv;
	logic signed [95:0]  w;
	logic signed [159:0] pe;
	logic signed [159:0] pc;
	logic signed [159:0] pg;
	logic signed [159:0] diff;

	lbfv_pkg::lbfv_item_t ma_q [MLN];
	logic [MLN-1:0]       ma_vld_q;

	logic                 vld_f_q;
	lbfv_pkg::lbfv_item_t item_f_q;
	lbfv_pkg::lbfv_rs_t   e_f_q;
	logic signed [95:0]   m_q;

	lbfv_pkg::lbfv_item_t mb_q [MLN];
	lbfv_pkg::lbfv_rs_t   eb_q [MLN];
	logic [MLN-1:0]       mb_vld_q;

	logic signed [159:0] px;
	logic signed [159:0] py;
	logic signed [159:0] pz;
	lbfv_pkg::lbfv_rs_t  rx;
	lbfv_pkg::lbfv_rs_t  ry;
	lbfv_pkg::lbfv_rs_t  rz;
	lbfv_pkg::lbfv_item_t fin;
	lbfv_pkg::lbfv_rs_t  efin;
	lbfv_pkg::lbfv_out_t res;

	assign dsub = lbfv_pkg::ONE_Q44 - head.ent.vsq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0   <= 1'b0;
			sq_vld_q <= '0;
			d1_vld_q <= '0;
			d2_vld_q <= '0;
			ma_vld_q <= '0;
			vld_f_q  <= 1'b0;
			mb_vld_q <= '0;
			done     <= 1'b0;
		end else begin
			vld_s0   <= head.vld;
			sq_vld_q <= {sq_vld_q[SQN-2:0], vld_s0};
			d1_vld_q <= {d1_vld_q[DVN-2:0], sq_vld_q[SQN-1]};
			d2_vld_q <= {d2_vld_q[DVN-2:0], d1_vld_q[DVN-1]};
			ma_vld_q <= {ma_vld_q[MLN-2:0], d2_vld_q[DVN-1]};
			vld_f_q  <= ma_vld_q[MLN-1];
			mb_vld_q <= {mb_vld_q[MLN-2:0], vld_f_q};
			done     <= mb_vld_q[MLN-1];
		end
	end

	always_ff @(posedge clk) begin
		item_s0 <= head.ent.item;
		if (head.ent.item.kind == lbfv_pkg::ST_BOOST) begin
			x_s0 <= {1'b0, dsub[44:0], 18'b0};
		end else begin
			x_s0 <= 64'h4000_0000_0000_0000;
		end
	end

	// square root, two radicand bits per step
	always_comb begin
		sq_init      = '0;
		sq_init.item = item_s0;
		sq_init.x    = x_s0;
	end

	for (genvar k = 0; k < SQN; k++) begin : g_sq
		sq_t         cur;
		sq_t         nxt;
		logic [35:0] r2;
		logic [35:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign cur = sq_init;
		end else begin : g_next
			assign cur = sq_q[k-1];
		end
		always_comb begin
			r2    = {cur.rem[33:0], cur.x[63:62]};
			trial = {2'b00, cur.root, 2'b01};
			ge    = r2 >= trial;
			nxt      = cur;
			nxt.rem  = ge ? r2 - trial : r2;
			nxt.root = {cur.root[30:0], ge};
			nxt.x    = {cur.x[61:0], 2'b00};
		end
		assign sq_nxt[k] = nxt;
	end

	always_ff @(posedge clk) begin
		sq_q <= sq_nxt;
	end

	// gamma = 2^63 / s, leading quotient bits are known zero
	always_comb begin
		d1_init      = '0;
		d1_init.item = sq_q[SQN-1].item;
		d1_init.rem  = 34'd256;
		d1_init.s    = sq_q[SQN-1].root;
	end

	for (genvar j = 0; j < DVN; j++) begin : g_d1
		d1_t         cur;
		d1_t         nxt;
		logic [33:0] r2;
		logic        ge;
		if (j == 0) begin : g_first
			assign cur = d1_init;
		end else begin : g_next
			assign cur = d1_q[j-1];
		end
		always_comb begin
			r2  = {cur.rem[32:0], 1'b0};
			ge  = r2 >= {2'b00, cur.s};
			nxt     = cur;
			nxt.rem = ge ? r2 - {2'b00, cur.s} : r2;
			nxt.q   = {cur.q[53:0], ge};
		end
		assign d1_nxt[j] = nxt;
	end

	always_ff @(posedge clk) begin
		d1_q <= d1_nxt;
	end

	// c = gamma * 2^31 / (2^31 + s)
	always_comb begin
		d2_init      = '0;
		d2_init.item = d1_q[DVN-1].item;
		d2_init.gam  = d1_q[DVN-1].q;
		d2_init.rem  = {3'b000, d1_q[DVN-1].q[54:24]};
		d2_init.nb   = {d1_q[DVN-1].q[23:0], 31'b0};
		d2_init.t    = 33'h0_8000_0000 + {1'b0, d1_q[DVN-1].s};
	end

	for (genvar j = 0; j < DVN; j++) begin : g_d2
		d2_t         cur;
		d2_t         nxt;
		logic [33:0] r2;
		logic        ge;
		if (j == 0) begin : g_first
			assign cur = d2_init;
		end else begin : g_next
			assign cur = d2_q[j-1];
		end
		always_comb begin
			r2  = {cur.rem[32:0], cur.nb[54]};
			ge  = r2 >= {1'b0, cur.t};
			nxt     = cur;
			nxt.rem = ge ? r2 - {1'b0, cur.t} : r2;
			nxt.nb  = {cur.nb[53:0], 1'b0};
			nxt.q   = {cur.q[53:0], ge};
		end
		assign d2_nxt[j] = nxt;
	end

	always_ff @(posedge clk) begin
		d2_q <= d2_nxt;
	end

	assign dv = d2_q[DVN-1];
	assign w  = (96'(dv.item.vec.energy_in) <<< 22) - 96'(dv.item.vdp);

	lbfv_mul u_mul_e (.clk(clk), .a(w), .b({9'b0, dv.gam}), .p(pe));
	lbfv_mul u_mul_c (.clk(clk), .a(96'(dv.item.vdp)), .b({9'b0, dv.q}), .p(pc));
	lbfv_mul u_mul_g (.clk(clk), .a(96'(dv.item.vec.energy_in)), .b({9'b0, dv.gam}),
		.p(pg));

	assign diff = pc - (pg <<< 22);

	always_ff @(posedge clk) begin
		ma_q[0] <= dv.item;
		for (int i = 1; i < MLN; i++) begin
			ma_q[i] <= ma_q[i-1];
		end
		item_f_q <= ma_q[MLN-1];
		e_f_q    <= lbfv_pkg::rsat(pe, 54);
		m_q      <= 96'(diff >>> 32);
	end

	lbfv_mul u_mul_x (.clk(clk), .a(m_q), .b(64'(item_f_q.vec.vel_x)), .p(px));
	lbfv_mul u_mul_y (.clk(clk), .a(m_q), .b(64'(item_f_q.vec.vel_y)), .p(py));
	lbfv_mul u_mul_z (.clk(clk), .a(m_q), .b(64'(item_f_q.vec.vel_z)), .p(pz));

	always_ff @(posedge clk) begin
		mb_q[0] <= item_f_q;
		eb_q[0] <= e_f_q;
		for (int i = 1; i < MLN; i++) begin
			mb_q[i] <= mb_q[i-1];
			eb_q[i] <= eb_q[i-1];
		end
	end

	assign fin  = mb_q[MLN-1];
	assign efin = eb_q[MLN-1];
	assign rx   = lbfv_pkg::rsat((160'(fin.vec.mom_x_in) <<< 44) + px, 44);
	assign ry   = lbfv_pkg::rsat((160'(fin.vec.mom_y_in) <<< 44) + py, 44);
	assign rz   = lbfv_pkg::rsat((160'(fin.vec.mom_z_in) <<< 44) + pz, 44);

	always_comb begin
		if (fin.kind == lbfv_pkg::ST_BOOST) begin
			res.energy_out = efin.val;
			res.mom_x_out  = rx.val;
			res.mom_y_out  = ry.val;
			res.mom_z_out  = rz.val;
			res.status     = (efin.sat || rx.sat || ry.sat || rz.sat) ?
				lbfv_pkg::ST_SAT : lbfv_pkg::ST_BOOST;
		end else begin
			res.energy_out = fin.vec.energy_in;
			res.mom_x_out  = fin.vec.mom_x_in;
			res.mom_y_out  = fin.vec.mom_y_in;
			res.mom_z_out  = fin.vec.mom_z_in;
			res.status     = fin.kind;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

endmodule

// File: hdl/lorentz_boost_four_vector.sv
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector
// General-direction Lorentz boost of a Q15.16 four-momentum by a Q1.22 frame
// velocity. One item is taken per clock cycle while busy is low, and each
// result appears on result, marked by done; the pipeline depth comes from
// the square root (32 steps) and the two restoring divisions (55 steps
// each) that form gamma and the combined coefficient, plus two ranks of
// four-stage wide multipliers. Results cannot be held off. A zero velocity
// or a speed not below one passes the input through with status 1 or 2; a
// clamped output gives status 3.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lbfv_pkg::lbfv_in_t  item,
	output logic                busy,
	output logic                done,
	output lbfv_pkg::lbfv_out_t result
);

	lbfv_pkg::lbfv_qlink_t       push;
	lbfv_pkg::lbfv_qlink_t       head;
	logic [lbfv_pkg::QCNT_W-1:0] cnt;

	lbfv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cnt    (cnt),
		.busy   (busy),
		.push   (push)
	);

	lbfv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.head   (head),
		.cnt    (cnt)
	);

	lbfv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.done   (done),
		.result (result)
	);

endmodule

// File: hdl/lbfv_checker.sv
// ----------------------------------------------------------------------------
// lbfv_checker
// Port-level checks of the boost block: latency, pass-through items, reset.
// ----------------------------------------------------------------------------
module lbfv_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input lbfv_pkg::lbfv_in_t  item,
	input logic                busy,
	input logic                done,
	input lbfv_pkg::lbfv_out_t result
);

	a_no_done_at_reset_release: assert property (@(posedge clk)
		$rose(arst_n) |-> !done)
		else $error("result strobe right after reset");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, lbfv_pkg::LATENCY))
		else $error("result without matching item");

	a_zero_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == lbfv_pkg::ST_ZERO) |->
		(result.energy_out == $past(item.energy_in, lbfv_pkg::LATENCY)
		&& result.mom_x_out == $past(item.mom_x_in, lbfv_pkg::LATENCY)))
		else $error("zero velocity item altered");

	a_fast_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == lbfv_pkg::ST_FAST) |->
		(result.mom_z_out == $past(item.mom_z_in, lbfv_pkg::LATENCY)))
		else $error("over-speed item altered");

endmodule

bind lorentz_boost_four_vector lbfv_checker u_lbfv_checker (.*);
